// File: rtl/dpsc_pkg.sv
// Shared types and constants for the dual-lane PID speed regulator.
// No dependencies; every other file refers to it by scoped names.
package dpsc_pkg;

  localparam int NUM_LANES      = 2;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_W         = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int TARGET_W       = 8;
  localparam int SPEED_W        = 24;
  localparam int ERR_W          = 18;
  localparam int DRIVE_W        = 16;
  localparam int ALPHA_W        = 17;
  localparam int ILIM_W         = 31;
  localparam int DLIM_W         = 15;
  localparam int ALPHA_SHIFT    = 16;

  // speed / 104 = ((|speed| >> 3) * DIV_MUL) >> DIV_RSH, exact over 21-bit operands
  localparam int DIV_PRE_SHIFT  = 3;
  localparam int DIV_MUL_W      = 22;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 22'd2581111;
  localparam int DIV_RSH        = 25;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [DATA_W-1:0]  S32_MAX   = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]  S32_MIN   = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_DT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_OVER_DT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DLIM      = 3'd5;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki_dt;
    logic signed [DATA_W-1:0] kd_over_dt;
    logic [ALPHA_W-1:0]       alpha;
    logic [ILIM_W-1:0]        integral_limit;
    logic [DLIM_W-1:0]        drive_limit;
  } cfg_t;

  // one-cycle strobes from the sequencer to every lane
  typedef struct packed {
    logic load;
    logic clear;
    logic div;
    logic mul;
    logic acc;
    logic filt;
    logic upd;
    logic sum;
  } stage_ctl_t;

endpackage

// File: rtl/dpsc_seq.sv
// Step sequencer for the lanes: accepts items and issues stage strobes.
// Depends on dpsc_pkg.
module dpsc_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_op,
  input  logic                   out_free,
  output logic                   in_stall,
  output dpsc_pkg::stage_ctl_t   ctl
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_FILT = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_SUM  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == dpsc_pkg::OP_CLEAR) begin
            ctl.clear = 1'b1;
          end else begin
            ctl.load  = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        ctl.div   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc   = 1'b1;
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        ctl.filt  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctl.upd   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // hold until the output register can take the result
        if (out_free) begin
          ctl.sum   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/dpsc_lane.sv
// One PID lane: error, integrator, filtered derivative and clamped drive.
// Depends on dpsc_pkg; stepped by strobes from dpsc_seq.
module dpsc_lane #(
  parameter int FRAC_BITS = dpsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dpsc_pkg::stage_ctl_t                   ctl,
  input  dpsc_pkg::cfg_t                         cfg,
  input  logic signed [dpsc_pkg::TARGET_W-1:0]   in_target,
  input  logic signed [dpsc_pkg::SPEED_W-1:0]    in_speed,
  output logic signed [dpsc_pkg::DRIVE_W-1:0]    drive
);

  localparam int ERR_W  = dpsc_pkg::ERR_W;
  localparam int P_W    = dpsc_pkg::DATA_W + ERR_W;       // 50
  localparam int D_W    = dpsc_pkg::DATA_W + ERR_W + 1;   // 51
  localparam int FM_W   = dpsc_pkg::DATA_W + 1 + dpsc_pkg::ALPHA_W + 1; // 51
  localparam int FS_W   = FM_W - dpsc_pkg::ALPHA_SHIFT;   // 35
  localparam int SUM_W  = P_W + 2;                        // 52
  localparam int X_W    = dpsc_pkg::SPEED_W - dpsc_pkg::DIV_PRE_SHIFT;
  localparam int PR_W   = X_W + dpsc_pkg::DIV_MUL_W;

  // item operands
  logic signed [dpsc_pkg::TARGET_W-1:0] target_r;
  logic signed [dpsc_pkg::SPEED_W-1:0]  speed_r;

  // working registers
  logic signed [ERR_W-1:0]            err_r, err_nxt;
  logic signed [P_W-1:0]              p_r, p_nxt;
  logic signed [P_W-1:0]              ip_r, ip_nxt;
  logic signed [D_W-1:0]              dp_r, dp_nxt;
  logic signed [dpsc_pkg::DATA_W-1:0] raw_r, raw_nxt;
  logic signed [FM_W-1:0]             fm_r, fm_nxt;

  // lane state
  logic signed [dpsc_pkg::DATA_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]            prev_err_r;
  logic signed [dpsc_pkg::DATA_W-1:0] fd_r, fd_nxt;

  // divide step
  logic [dpsc_pkg::SPEED_W-1:0] sp_mag;
  logic [X_W-1:0]               sp_x;
  logic [PR_W-1:0]              q_prod;
  logic [ERR_W-1:0]             q_mag;
  logic signed [ERR_W:0]        err_wide;

  // multiply step
  logic signed [ERR_W:0]        err_diff;

  // accumulate step
  logic signed [D_W-1:0]        acc_sum;
  logic signed [D_W-1:0]        acc_lim;
  logic signed [D_W-1:0]        acc_nlim;

  // filter steps
  logic signed [dpsc_pkg::DATA_W:0]    fd_diff;
  logic signed [dpsc_pkg::ALPHA_W:0]   alpha_s;
  logic signed [FS_W:0]                fd_sum;

  // sum step
  logic signed [SUM_W-1:0] tot;
  logic signed [SUM_W-1:0] tot_lim;
  logic signed [SUM_W-1:0] tot_clamp;
  logic [SUM_W-1:0]        tot_mag;
  logic [SUM_W-1:0]        tot_q;

  always_comb begin
    sp_mag   = speed_r[dpsc_pkg::SPEED_W-1] ? (~speed_r + 1'b1) : speed_r;
    sp_x     = sp_mag[dpsc_pkg::SPEED_W-1:dpsc_pkg::DIV_PRE_SHIFT];
    q_prod   = PR_W'(sp_x) * PR_W'(dpsc_pkg::DIV_MUL);
    q_mag    = q_prod[dpsc_pkg::DIV_RSH +: ERR_W];
    if (speed_r[dpsc_pkg::SPEED_W-1]) begin
      err_wide = (ERR_W+1)'(target_r) + $signed({1'b0, q_mag});
    end else begin
      err_wide = (ERR_W+1)'(target_r) - $signed({1'b0, q_mag});
    end
    err_nxt  = err_wide[ERR_W-1:0];
  end

  always_comb begin
    err_diff = (ERR_W+1)'(err_r) - (ERR_W+1)'(prev_err_r);
    p_nxt    = P_W'(cfg.kp) * P_W'(err_r);
    ip_nxt   = P_W'(cfg.ki_dt) * P_W'(err_r);
    dp_nxt   = D_W'(cfg.kd_over_dt) * D_W'(err_diff);
  end

  always_comb begin
    acc_sum  = D_W'(integ_r) + D_W'(ip_r);
    acc_lim  = $signed(D_W'(cfg.integral_limit));
    acc_nlim = -acc_lim;
    if (cfg.ki_dt == '0) begin
      integ_nxt = '0;
    end else if (acc_sum > acc_lim) begin
      integ_nxt = acc_lim[dpsc_pkg::DATA_W-1:0];
    end else if (acc_sum < acc_nlim) begin
      integ_nxt = acc_nlim[dpsc_pkg::DATA_W-1:0];
    end else begin
      integ_nxt = acc_sum[dpsc_pkg::DATA_W-1:0];
    end
    // saturate the raw derivative to 32 bits
    if (dp_r[D_W-1:dpsc_pkg::DATA_W-1] == {(D_W-dpsc_pkg::DATA_W+1){dp_r[D_W-1]}}) begin
      raw_nxt = dp_r[dpsc_pkg::DATA_W-1:0];
    end else begin
      raw_nxt = dp_r[D_W-1] ? dpsc_pkg::S32_MIN : dpsc_pkg::S32_MAX;
    end
  end

  always_comb begin
    fd_diff = (dpsc_pkg::DATA_W+1)'(raw_r) - (dpsc_pkg::DATA_W+1)'(fd_r);
    alpha_s = $signed({1'b0, cfg.alpha});
    fm_nxt  = FM_W'(fd_diff) * FM_W'(alpha_s);
  end

  always_comb begin
    // arithmetic shift floors toward minus infinity
    fd_sum = (FS_W+1)'(fd_r) + (FS_W+1)'($signed(fm_r[FM_W-1:dpsc_pkg::ALPHA_SHIFT]));
    if (fd_sum[FS_W:dpsc_pkg::DATA_W-1] == {(FS_W-dpsc_pkg::DATA_W+2){fd_sum[FS_W]}}) begin
      fd_nxt = fd_sum[dpsc_pkg::DATA_W-1:0];
    end else begin
      fd_nxt = fd_sum[FS_W] ? dpsc_pkg::S32_MIN : dpsc_pkg::S32_MAX;
    end
  end

  always_comb begin
    tot     = SUM_W'(p_r) + SUM_W'(integ_r) + SUM_W'(fd_r);
    tot_lim = $signed(SUM_W'({cfg.drive_limit, {FRAC_BITS{1'b0}}}));
    if (tot > tot_lim) begin
      tot_clamp = tot_lim;
    end else if (tot < -tot_lim) begin
      tot_clamp = -tot_lim;
    end else begin
      tot_clamp = tot;
    end
    tot_mag = tot_clamp[SUM_W-1] ? SUM_W'(-tot_clamp) : SUM_W'(tot_clamp);
    tot_q   = tot_mag >> FRAC_BITS;
    // truncate toward zero: shift the magnitude, then restore the sign
    drive   = tot_clamp[SUM_W-1] ? -$signed(tot_q[dpsc_pkg::DRIVE_W-1:0])
                                 : $signed(tot_q[dpsc_pkg::DRIVE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      target_r <= in_target;
      speed_r  <= in_speed;
    end
    if (ctl.div) begin
      err_r <= err_nxt;
    end
    if (ctl.mul) begin
      p_r  <= p_nxt;
      ip_r <= ip_nxt;
      dp_r <= dp_nxt;
    end
    if (ctl.acc) begin
      raw_r <= raw_nxt;
    end
    if (ctl.filt) begin
      fm_r <= fm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
      fd_r       <= '0;
    end else begin
      if (ctl.clear) begin
        integ_r <= '0;
      end else if (ctl.acc) begin
        integ_r <= integ_nxt;
      end
      // zero derivative gain holds the filter and the previous error
      if (ctl.upd && (cfg.kd_over_dt != '0)) begin
        fd_r       <= fd_nxt;
        prev_err_r <= err_r;
      end
    end
  end

endmodule

// File: rtl/dpsc_merge.sv
// Output register that gathers the drive of every lane into one result item.
// Depends on dpsc_pkg.
module dpsc_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic signed [dpsc_pkg::DRIVE_W-1:0]  lane_drive [dpsc_pkg::NUM_LANES],
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 out_free,
  output logic signed [dpsc_pkg::DRIVE_W-1:0]  drive_q [dpsc_pkg::NUM_LANES]
);

  logic                                valid_r;
  logic signed [dpsc_pkg::DRIVE_W-1:0] drive_r [dpsc_pkg::NUM_LANES];

  assign out_valid = valid_r;
  assign out_free  = !valid_r || !out_stall;
  assign drive_q   = drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= lane_drive;
    end
  end

endmodule

// File: rtl/dual_pid_speed_control_unit.sv
// Dual-lane PID speed regulator with shared gains.
// Input channel: in_valid/in_stall with in_op and a target and raw encoder
// speed per wheel. in_op clear zeroes both integrators and gives no result.
// Result channel: out_valid/out_stall with left_drive and right_drive, the
// clamped throttle commands truncated toward zero.
// Configuration: cfg_we/cfg_index/cfg_data write one gain or limit a cycle;
// indexes past drive_limit are ignored. Write only while the block is idle.
// Sequencing: a control tick runs from acceptance to out_valid through the
// lane step chain (divide, gain multiplies, integrate, filter multiply,
// filter update, sum). A new item is taken in the cycle after the previous
// result is loaded, so ticks do not overlap; a clear leaves the sequencer
// idle. in_stall stays high while a tick is in progress.
// The output register holds a finished result while out_stall is high and
// the next tick may proceed meanwhile; its final step waits for the register.
// Reset (rst_n low, synchronous) zeroes all lane state and gains, sets the
// filter factor to unity and drops out_valid.
// Depends on dpsc_pkg, dpsc_seq, dpsc_lane, dpsc_merge.
module dual_pid_speed_control_unit #(
  parameter int FRAC_BITS = dpsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic signed [dpsc_pkg::TARGET_W-1:0]  in_left_target,
  input  logic signed [dpsc_pkg::SPEED_W-1:0]   in_left_speed,
  input  logic signed [dpsc_pkg::TARGET_W-1:0]  in_right_target,
  input  logic signed [dpsc_pkg::SPEED_W-1:0]   in_right_speed,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dpsc_pkg::DRIVE_W-1:0]   out_left_drive,
  output logic signed [dpsc_pkg::DRIVE_W-1:0]   out_right_drive,
  input  logic                                  cfg_we,
  input  logic [dpsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpsc_pkg::DATA_W-1:0]           cfg_data
);

  logic signed [dpsc_pkg::DATA_W-1:0] kp_r;
  logic signed [dpsc_pkg::DATA_W-1:0] ki_dt_r;
  logic signed [dpsc_pkg::DATA_W-1:0] kd_over_dt_r;
  logic [dpsc_pkg::ALPHA_W-1:0]       lpf_alpha_r;
  logic [dpsc_pkg::ILIM_W-1:0]        integral_limit_r;
  logic [dpsc_pkg::DLIM_W-1:0]        drive_limit_r;

  dpsc_pkg::cfg_t       cfg;
  dpsc_pkg::stage_ctl_t ctl;
  logic                 out_free;

  logic signed [dpsc_pkg::TARGET_W-1:0] lane_target [dpsc_pkg::NUM_LANES];
  logic signed [dpsc_pkg::SPEED_W-1:0]  lane_speed  [dpsc_pkg::NUM_LANES];
  logic signed [dpsc_pkg::DRIVE_W-1:0]  lane_drive  [dpsc_pkg::NUM_LANES];
  logic signed [dpsc_pkg::DRIVE_W-1:0]  drive_q     [dpsc_pkg::NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r             <= '0;
      ki_dt_r          <= '0;
      kd_over_dt_r     <= '0;
      lpf_alpha_r      <= dpsc_pkg::ALPHA_ONE;
      integral_limit_r <= '0;
      drive_limit_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpsc_pkg::REG_KP:         kp_r             <= cfg_data;
        dpsc_pkg::REG_KI_DT:      ki_dt_r          <= cfg_data;
        dpsc_pkg::REG_KD_OVER_DT: kd_over_dt_r     <= cfg_data;
        dpsc_pkg::REG_LPF_ALPHA:  lpf_alpha_r      <= cfg_data[dpsc_pkg::ALPHA_W-1:0];
        dpsc_pkg::REG_ILIM:       integral_limit_r <= cfg_data[dpsc_pkg::ILIM_W-1:0];
        dpsc_pkg::REG_DLIM:       drive_limit_r    <= cfg_data[dpsc_pkg::DLIM_W-1:0];
        default: begin
          // drop writes past the last register
        end
      endcase
    end
  end

  always_comb begin
    cfg.kp             = kp_r;
    cfg.ki_dt          = ki_dt_r;
    cfg.kd_over_dt     = kd_over_dt_r;
    // factors above unity act as unity
    cfg.alpha          = lpf_alpha_r[dpsc_pkg::ALPHA_W-1] ? dpsc_pkg::ALPHA_ONE : lpf_alpha_r;
    cfg.integral_limit = integral_limit_r;
    cfg.drive_limit    = drive_limit_r;
  end

  assign lane_target[0] = in_left_target;
  assign lane_speed[0]  = in_left_speed;
  assign lane_target[1] = in_right_target;
  assign lane_speed[1]  = in_right_speed;

  dpsc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  for (genvar g = 0; g < dpsc_pkg::NUM_LANES; g++) begin : g_lane
    dpsc_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cfg       (cfg),
      .in_target (lane_target[g]),
      .in_speed  (lane_speed[g]),
      .drive     (lane_drive[g])
    );
  end

  dpsc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.sum),
    .lane_drive (lane_drive),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_free   (out_free),
    .drive_q    (drive_q)
  );

  assign out_left_drive  = drive_q[0];
  assign out_right_drive = drive_q[1];

endmodule
